// File: design/assert_macros.svh
// Assertion macros shared by the checker of the two-queue merge block.
// Every macro samples on the rising edge of i_clk in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define PSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Next-cycle implication, ignored while reset is held.
`define PSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

// Next-cycle implication that is checked during reset as well.
`define PSW_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("reset property failed");

`endif

// File: design/psw_pkg.sv
// Shared constants, types and helpers of the parity-split weighted queue merge.
// Used by the front, back and top-level modules; depends on nothing else.
package psw_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_BITS     = 16;
    localparam int ODD_WEIGHT  = 2;

    localparam int PORT_ID_W = 16;
    localparam int STORE_W   = (ID_BITS < PORT_ID_W) ? ID_BITS : PORT_ID_W;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int WGT_W     = $clog2(ODD_WEIGHT + 1);

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd_code;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_back_state;

    // One classified transaction on its way from the front to the back.
    typedef struct packed {
        t_cmd_code          code;
        logic               is_odd;
        logic [STORE_W-1:0] id;
    } t_cmd;

    // Handshake between front and back.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

    // One result waiting in the output queue.
    typedef struct packed {
        logic [STORE_W-1:0] id;
        logic               last;
        logic               ovf;
    } t_res;

    // Circular pointer advance for a depth that need not be a power of two.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

endpackage

// File: design/psw_front.sv
// Front end: accepts input transactions, classifies them by command and parity,
// and holds them in a two-entry command queue. Depends on psw_pkg.
module psw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [psw_pkg::PORT_ID_W-1:0] i_customer_id,
    output psw_pkg::t_cmd_chan            o_chan,
    input  logic                          i_pop
);
    import psw_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    // Only the low ID_BITS of the number are kept, and parity is taken after that.
    always_comb begin
        w_cmd.code   = t_cmd_code'(i_cmd);
        w_cmd.id     = i_customer_id[STORE_W-1:0];
        w_cmd.is_odd = i_customer_id[0];
    end

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    always_comb begin
        o_chan.valid = (r_cnt != 2'd0);
        o_chan.cmd   = r_q[r_rptr];
    end

endmodule

// File: design/psw_back.sv
// Back end: odd and even stores, the weighted drain sequencer and the output queue.
// Depends on psw_pkg.
module psw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psw_pkg::t_cmd_chan            i_chan,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [psw_pkg::PORT_ID_W-1:0] o_served_id,
    output logic                          o_is_last,
    output logic                          o_overflowed
);
    import psw_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;

    logic [STORE_W-1:0] r_odd_mem  [QUEUE_DEPTH];
    logic [STORE_W-1:0] r_even_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_odd_head;
    logic [PTR_W-1:0]   r_odd_tail;
    logic [CNT_W-1:0]   r_odd_cnt;
    logic [PTR_W-1:0]   r_even_head;
    logic [PTR_W-1:0]   r_even_tail;
    logic [CNT_W-1:0]   r_even_cnt;
    logic               r_drop;
    logic               r_ovf;
    logic [WGT_W-1:0]   r_wcnt;

    logic               r_rd_vld;
    logic [STORE_W-1:0] r_rd_data;
    logic               r_rd_last;
    logic               r_rd_ovf;

    t_res               r_oq [2];
    logic               r_oq_wptr;
    logic               r_oq_rptr;
    logic [1:0]         r_oq_cnt;

    logic               w_push;
    logic               w_flush;
    logic               w_oq_pop;
    logic [2:0]         w_occ;
    logic               w_issue;
    logic               w_pick_odd;
    logic               w_last;
    logic               w_odd_full;
    logic               w_even_full;
    t_res               w_head;

    assign w_push  = o_pop && (i_chan.cmd.code == CMD_PUSH);
    assign w_flush = o_pop && (i_chan.cmd.code == CMD_FLUSH);

    assign w_odd_full  = (r_odd_cnt == CNT_W'(QUEUE_DEPTH));
    assign w_even_full = (r_even_cnt == CNT_W'(QUEUE_DEPTH));

    // A read may start only if its result will find room in the output queue.
    assign w_oq_pop = (r_oq_cnt != 2'd0) && !i_stall;
    assign w_occ    = {1'b0, r_oq_cnt} + {2'b00, r_rd_vld} - {2'b00, w_oq_pop};
    assign w_issue  = (r_state == ST_DRAIN) && (w_occ < 3'd2);

    // Odd entries are served while the round allows it, or when no even entry is left.
    assign w_pick_odd = (r_odd_cnt != '0)
        && ((r_wcnt < WGT_W'(ODD_WEIGHT)) || (r_even_cnt == '0));
    assign w_last = (({1'b0, r_odd_cnt} + {1'b0, r_even_cnt}) == (CNT_W + 1)'(1));

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop = i_chan.valid;
                if (i_chan.valid && (i_chan.cmd.code == CMD_FLUSH)
                    && ((r_odd_cnt != '0) || (r_even_cnt != '0))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_issue && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_odd_head  <= '0;
            r_odd_tail  <= '0;
            r_odd_cnt   <= '0;
            r_even_head <= '0;
            r_even_tail <= '0;
            r_even_cnt  <= '0;
            r_drop      <= 1'b0;
            r_ovf       <= 1'b0;
            r_wcnt      <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (w_push) begin
                if (i_chan.cmd.is_odd) begin
                    if (w_odd_full) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_odd_tail <= ptr_inc(r_odd_tail);
                        r_odd_cnt  <= r_odd_cnt + 1'b1;
                    end
                end else begin
                    if (w_even_full) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_even_tail <= ptr_inc(r_even_tail);
                        r_even_cnt  <= r_even_cnt + 1'b1;
                    end
                end
            end
            if (w_flush) begin
                r_ovf  <= r_drop;
                r_drop <= 1'b0;
                r_wcnt <= '0;
            end
            if (w_issue) begin
                if (w_pick_odd) begin
                    r_odd_head <= ptr_inc(r_odd_head);
                    r_odd_cnt  <= r_odd_cnt - 1'b1;
                    if (r_wcnt < WGT_W'(ODD_WEIGHT)) begin
                        r_wcnt <= r_wcnt + 1'b1;
                    end else begin
                        r_wcnt <= WGT_W'(1);
                    end
                end else begin
                    r_even_head <= ptr_inc(r_even_head);
                    r_even_cnt  <= r_even_cnt - 1'b1;
                    r_wcnt      <= '0;
                end
            end
        end
    end

    // Store writes and the registered read port.
    always_ff @(posedge i_clk) begin
        if (w_push && i_chan.cmd.is_odd && !w_odd_full) begin
            r_odd_mem[r_odd_tail] <= i_chan.cmd.id;
        end
        if (w_push && !i_chan.cmd.is_odd && !w_even_full) begin
            r_even_mem[r_even_tail] <= i_chan.cmd.id;
        end
        if (w_issue) begin
            if (w_pick_odd) begin
                r_rd_data <= r_odd_mem[r_odd_head];
            end else begin
                r_rd_data <= r_even_mem[r_even_head];
            end
            r_rd_last <= w_last;
            r_rd_ovf  <= r_ovf;
        end
    end

    // Two-entry output queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wptr <= 1'b0;
            r_oq_rptr <= 1'b0;
            r_oq_cnt  <= 2'd0;
        end else begin
            r_oq_cnt <= w_occ[1:0];
            if (r_rd_vld) begin
                r_oq_wptr <= ~r_oq_wptr;
            end
            if (w_oq_pop) begin
                r_oq_rptr <= ~r_oq_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_oq[r_oq_wptr] <= '{id: r_rd_data, last: r_rd_last, ovf: r_rd_ovf};
        end
    end

    assign w_head       = r_oq[r_oq_rptr];
    assign o_valid      = (r_oq_cnt != 2'd0);
    assign o_served_id  = PORT_ID_W'(w_head.id);
    assign o_is_last    = w_head.last;
    assign o_overflowed = w_head.ovf;

endmodule

// File: design/parity_split_weighted_queue_merge.sv
// Pushes are accepted one per cycle unless the front end stalls, and go to their store when the
// back end pops them. A flush passes the front-end queue, drain state, read register and output
// queue before its first result, then one result per cycle unless the output stalls; one read
// per cycle from the stores sets that rate. The back end is busy until all entries are read; an
// empty flush emits nothing, and the front end stalls input once it holds two transactions.
// Reset is synchronous, active low, and empties all queues at once; store contents stay.
//
// Top level of the parity-split weighted queue merge. Instantiates psw_front and
// psw_back and depends on psw_pkg.
module parity_split_weighted_queue_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [psw_pkg::PORT_ID_W-1:0] i_customer_id,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [psw_pkg::PORT_ID_W-1:0] o_served_id,
    output logic                          o_is_last,
    output logic                          o_overflowed
);
    import psw_pkg::*;

    // Command channel from the front end to the back end. The front end holds up to
    // two classified transactions, so it takes in up to two more while the back end drains.
    t_cmd_chan w_chan;
    logic      w_pop;

    // The front end registers each transaction, keeps only the low ID_BITS of the
    // customer number and tags it as odd or even. Its stall comes from its own fill
    // level only, never from the downstream stall.
    psw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_customer_id (i_customer_id),
        .o_chan        (w_chan),
        .i_pop         (w_pop)
    );

    // The back end executes commands in order. A push writes the odd or even store,
    // or sets the sticky overflow flag when that store is full. A flush captures the
    // flag for all of its results, clears it, and then drains both stores in a 2:1
    // weighted round robin. Each step reads one store entry into a register and then
    // into a two-entry output queue, which absorbs a stall on the output side.
    psw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chan       (w_chan),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_served_id  (o_served_id),
        .o_is_last    (o_is_last),
        .o_overflowed (o_overflowed)
    );

endmodule

// File: design/psw_checker.sv
// Port-level checker for the parity-split weighted queue merge, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module psw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_served_id,
    input logic        o_is_last,
    input logic        o_overflowed
);

    // Tracks whether a flush burst is in progress and the flag its results carry.
    logic r_in_burst;
    logic r_burst_ovf;
    logic w_out_xfer;

    assign w_out_xfer = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_burst  <= 1'b0;
            r_burst_ovf <= 1'b0;
        end else if (w_out_xfer) begin
            r_in_burst  <= !o_is_last;
            r_burst_ovf <= o_overflowed;
        end
    end

    `PSW_ASSERT_NEXT(a_valid_holds, o_valid && i_stall, o_valid)
    `PSW_ASSERT_NEXT(a_result_holds, o_valid && i_stall, $stable(o_served_id) && $stable(o_is_last))
    `PSW_ASSERT_NOW(a_burst_ovf_same, o_valid && r_in_burst, o_overflowed == r_burst_ovf)
    `PSW_ASSERT_NEXT_ALWAYS(a_reset_quiet, !i_rst_n, !o_valid && !o_stall)

endmodule

bind parity_split_weighted_queue_merge psw_checker u_psw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_served_id  (o_served_id),
    .o_is_last    (o_is_last),
    .o_overflowed (o_overflowed)
);

// File: tb/parity_split_weighted_queue_merge_tb.sv
// Self-checking testbench for the parity-split weighted queue merge block.
// Depends on psw_pkg and parity_split_weighted_queue_merge; holds its own
// model of the two queues and checks every served result against it.
`timescale 1ns / 1ps

module parity_split_weighted_queue_merge_tb;

    import psw_pkg::*;

    localparam int ID_W          = PORT_ID_W;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 8;
    // A short settle after the last result covers anything still moving inside
    // the block.
    localparam int SETTLE_CYCLES = 10;
    // Cycles in a row with no transaction on either side before the run is
    // declared hung. The longest correct quiet stretch is a sender gap or a
    // drain pause plus the settle, far below this.
    localparam int HANG_LIMIT    = 1000;
    localparam int RANDOM_ITEMS  = 175;

    // One served customer as the block should present it.
    typedef struct {
        logic [ID_W-1:0] id;
        logic            last;
        logic            ovf;
    } t_served_rec;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_valid       = 1'b0;
    logic            i_cmd         = CMD_PUSH;
    logic [ID_W-1:0] i_customer_id = '0;
    logic            i_stall       = 1'b0;
    logic            o_stall;
    logic            o_valid;
    logic [ID_W-1:0] o_served_id;
    logic            o_is_last;
    logic            o_overflowed;

    // Model state: the two parity queues and the sticky drop flag.
    logic [ID_W-1:0] odd_line[$];
    logic [ID_W-1:0] even_line[$];
    logic            drop_seen = 1'b0;

    // Results the block still owes, oldest first.
    t_served_rec     served_due[$];

    int              mismatch_count = 0;
    int              items_sent     = 0;

    // Sender pacing: bursts of transactions separated by idle gaps.
    bit              gaps_on    = 1'b1;
    int              burst_left = 0;

    // Receiver stall pattern state.
    logic [8:0]      stall_phase = '0;

    parity_split_weighted_queue_merge u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_customer_id (i_customer_id),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_served_id   (o_served_id),
        .o_is_last     (o_is_last),
        .o_overflowed  (o_overflowed)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Apply one accepted transaction to the model. A push lands in the queue
    // of its parity unless that queue is full, in which case it is dropped and
    // the drop flag is set. A flush serves up to ODD_WEIGHT odd customers, then
    // one even customer, for as long as odd ones remain, then the rest of the
    // even queue. Every result of the flush carries the drop flag as it stood
    // when the flush arrived, and the flush clears it.
    function automatic void predict_service(input t_cmd_code code, input logic [ID_W-1:0] id);
        t_served_rec rec;
        logic [ID_W-1:0] kept;
        int first_idx;
        bit ovf;
        kept = id & ID_W'((64'd1 << ID_BITS) - 1);
        if (code == CMD_PUSH) begin
            if (kept[0]) begin
                if (odd_line.size() >= QUEUE_DEPTH) begin
                    drop_seen = 1'b1;
                end else begin
                    odd_line.push_back(kept);
                end
            end else begin
                if (even_line.size() >= QUEUE_DEPTH) begin
                    drop_seen = 1'b1;
                end else begin
                    even_line.push_back(kept);
                end
            end
            return;
        end
        ovf       = drop_seen;
        first_idx = served_due.size();
        rec.last  = 1'b0;
        rec.ovf   = ovf;
        while (odd_line.size() > 0) begin
            for (int w = 0; w < ODD_WEIGHT && odd_line.size() > 0; w++) begin
                rec.id = odd_line.pop_front();
                served_due.push_back(rec);
            end
            if (even_line.size() > 0) begin
                rec.id = even_line.pop_front();
                served_due.push_back(rec);
            end
        end
        while (even_line.size() > 0) begin
            rec.id = even_line.pop_front();
            served_due.push_back(rec);
        end
        // Only the final result of this flush is marked; an empty flush marks nothing.
        if (served_due.size() > first_idx) begin
            served_due[served_due.size() - 1].last = 1'b1;
        end
        drop_seen = 1'b0;
    endfunction

    // Present one transaction from a falling edge, hold it until the block
    // takes it, and return at the next falling edge. Between bursts the valid
    // drops for a random number of cycles.
    task automatic send_txn(input t_cmd_code code, input logic [ID_W-1:0] id);
        i_valid       = 1'b1;
        i_cmd         = code;
        i_customer_id = id;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        predict_service(code, id);
        items_sent++;
        @(negedge i_clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Hold the sender off until every owed result has come out, then let the
    // block settle and go quiet.
    task automatic wait_drained();
        i_valid = 1'b0;
        while (served_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Customer numbers with a bias toward the corners of the 16-bit range.
    function automatic logic [ID_W-1:0] pick_customer();
        logic [ID_W-1:0] id;
        case ($urandom_range(0, 7))
            0: id = $urandom_range(0, 1) ? '1 : '0;
            1: id = ID_W'(1) << $urandom_range(0, ID_W - 1);
            2: id = ~(ID_W'(1) << $urandom_range(0, ID_W - 1));
            default: id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
        endcase
        return id;
    endfunction

    // A flush with both queues empty must produce nothing at all.
    task automatic test_empty_flush();
        send_txn(CMD_FLUSH, '0);
        send_txn(CMD_FLUSH, 16'hFFFF);
        wait_drained();
    endtask

    // Corner values of the customer number, four of each parity, so the
    // flush shows the two-odd-then-one-even order and the even tail.
    task automatic test_corner_ids();
        send_txn(CMD_PUSH, 16'h0000);
        send_txn(CMD_PUSH, 16'hFFFF);
        send_txn(CMD_PUSH, 16'h0001);
        send_txn(CMD_PUSH, 16'hFFFE);
        send_txn(CMD_PUSH, 16'h8000);
        send_txn(CMD_PUSH, 16'h7FFF);
        send_txn(CMD_PUSH, 16'h5555);
        send_txn(CMD_PUSH, 16'hAAAA);
        send_txn(CMD_FLUSH, 16'h1234);
        wait_drained();
    endtask

    // One queue holding entries alone drains in order; a single entry carries
    // the last mark on its only result.
    task automatic test_single_queue();
        send_txn(CMD_PUSH, 16'h0003);
        send_txn(CMD_PUSH, 16'h0005);
        send_txn(CMD_PUSH, 16'h0007);
        send_txn(CMD_FLUSH, '0);
        send_txn(CMD_PUSH, 16'h0002);
        send_txn(CMD_PUSH, 16'h0004);
        send_txn(CMD_PUSH, 16'h0006);
        send_txn(CMD_FLUSH, '0);
        send_txn(CMD_PUSH, 16'hC001);
        send_txn(CMD_FLUSH, '0);
        wait_drained();
    endtask

    // Pushes past a full queue are dropped and every result of the next flush
    // reports it; the flush clears the flag, which the following batch shows.
    task automatic test_overflow();
        for (int n = 0; n < QUEUE_DEPTH + 2; n++) begin
            send_txn(CMD_PUSH, pick_customer() | ID_W'(1));
        end
        for (int n = 0; n < QUEUE_DEPTH + 1; n++) begin
            send_txn(CMD_PUSH, pick_customer() & ~ID_W'(1));
        end
        send_txn(CMD_FLUSH, '0);
        send_txn(CMD_PUSH, pick_customer());
        send_txn(CMD_PUSH, pick_customer());
        send_txn(CMD_FLUSH, '0);
        // Overflow on the even side only, with a few odd entries mixed in.
        for (int n = 0; n < QUEUE_DEPTH + 3; n++) begin
            send_txn(CMD_PUSH, pick_customer() & ~ID_W'(1));
            if (n % 12 == 5) begin
                send_txn(CMD_PUSH, pick_customer() | ID_W'(1));
            end
        end
        send_txn(CMD_FLUSH, '0);
        wait_drained();
    endtask

    // Random batches of pushes, each closed by a flush. Most batches are short;
    // a few fill a queue or spill over. Flushes often follow one another so a
    // new batch is pushed while the last one is still being served.
    task automatic test_random_batches();
        int start_count;
        int batch_len;
        int parity_mode;
        logic [ID_W-1:0] id;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0:       batch_len = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 8);
                1, 2, 3: batch_len = $urandom_range(11, QUEUE_DEPTH);
                default: batch_len = $urandom_range(0, 10);
            endcase
            parity_mode = $urandom_range(0, 7);
            for (int n = 0; n < batch_len; n++) begin
                id = pick_customer();
                if (parity_mode == 0) begin
                    id[0] = 1'b1;
                end else if (parity_mode == 1) begin
                    id[0] = 1'b0;
                end
                send_txn(CMD_PUSH, id);
            end
            send_txn(CMD_FLUSH, pick_customer());
            // Now and then the sender holds off until the block has served all.
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // The receiver stalls on a pattern picked by the top two bits of stall_phase:
    // no stall, random stalls, a short periodic stall and a long periodic stall.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[8:7])
            2'd0:    i_stall <= 1'b0;
            2'd1:    i_stall <= ($urandom_range(0, 2) == 0);
            2'd2:    i_stall <= (stall_phase[2:0] < 3'd3);
            default: i_stall <= (stall_phase[4:3] == 2'b00);
        endcase
    end

    // Compare each result the block hands over with the oldest one owed.
    always @(posedge i_clk) begin : served_check
        t_served_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (served_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual id %h last %b ovf %b",
                         $time, o_served_id, o_is_last, o_overflowed);
                mismatch_count++;
            end else begin
                want = served_due.pop_front();
                if (o_served_id !== want.id) begin
                    $display("%0t: served_id expected %h actual %h",
                             $time, want.id, o_served_id);
                    mismatch_count++;
                end
                if (o_is_last !== want.last) begin
                    $display("%0t: is_last expected %b actual %b",
                             $time, want.last, o_is_last);
                    mismatch_count++;
                end
                if (o_overflowed !== want.ovf) begin
                    $display("%0t: overflowed expected %b actual %b",
                             $time, want.ovf, o_overflowed);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if neither side moves a transaction for too long.
    initial begin : hang_watch
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Reset once, run the tests in turn, then report.
    initial begin
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_flush();
        test_corner_ids();
        test_single_queue();
        test_overflow();
        test_random_batches();

        wait_drained();
        if (served_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, served_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
